### hdl/phh_pkg.sv
// Shared types, constants and the full-scale range table for the
// pulse-height histogram unit. No dependencies.
package phh_pkg;

  localparam int SAMPLE_W    = 16;  // raw ADC code
  localparam int RB_W        = 8;   // read_bin / bin_number field
  localparam int CNT_FIELD_W = 32;  // bin_count field
  localparam int RANGE_W     = 4;
  localparam int FSC_W       = 15;
  localparam int RANGE_MV_W  = 16;
  localparam int PROD_W      = 34;  // extreme*range and edge*full_scale, signed
  localparam int DIFF_W      = 33;  // distance above the low edge, unsigned

  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 15;

  localparam int IN_TDATA_W  = 24;  // sample, read_bin
  localparam int OUT_TDATA_W = 56;  // event_extreme, bin_number, bin_count

  // register indices on the config port
  localparam logic [CFG_ADDR_W-1:0] CFG_POLARITY = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_RANGE    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_FSC      = 2'd2;

  localparam logic           POL_RST = 1'b1;
  localparam logic [RANGE_W-1:0] RANGE_RST = 4'd0;
  localparam logic [FSC_W-1:0]   FSC_RST   = 15'd32512;

  // input beat kind (tuser) and result kind (tuser)
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_READ   = 1'b1;
  localparam logic KIND_EVENT  = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_BIN   = 6'b000100,
    ST_RD    = 6'b001000,
    ST_RDW   = 6'b010000,
    ST_EMIT  = 6'b100000
  } top_state_t;

  typedef enum logic [4:0] {
    BS_IDLE  = 5'b00001,
    BS_MUL   = 5'b00010,
    BS_CMP   = 5'b00100,
    BS_SCALE = 5'b01000,
    BS_DIV   = 5'b10000
  } bin_state_t;

  // full-scale range in mV; indices past the table saturate to the top range
  function automatic logic [RANGE_MV_W-1:0] range_mv(input logic [RANGE_W-1:0] idx);
    logic [RANGE_MV_W-1:0] r;
    case (idx)
      4'd0:    r = 16'd10;
      4'd1:    r = 16'd20;
      4'd2:    r = 16'd50;
      4'd3:    r = 16'd100;
      4'd4:    r = 16'd200;
      4'd5:    r = 16'd500;
      4'd6:    r = 16'd1000;
      4'd7:    r = 16'd2000;
      4'd8:    r = 16'd5000;
      4'd9:    r = 16'd10000;
      4'd10:   r = 16'd20000;
      default: r = 16'd50000;
    endcase
    return r;
  endfunction

endpackage

### hdl/phh_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module phh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 202
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/phh_binner.sv
// Converts an event extreme to a histogram bin: product stage, edge compare,
// scaling and a bit-serial restoring divider. Uses phh_pkg.
module phh_binner #(
  parameter int NUM_BINS    = 200,
  parameter int HIST_LOW_MV = -100,
  parameter int HIST_HIGH_MV = 0
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [phh_pkg::SAMPLE_W-1:0] extreme,
  input  logic [phh_pkg::RANGE_W-1:0]         range_index,
  input  logic [phh_pkg::FSC_W-1:0]           full_scale_count,
  output logic                                done,
  output logic [$clog2(NUM_BINS+2)-1:0]       bin
);

  localparam int SLOTS = NUM_BINS + 2;
  localparam int BIN_W = $clog2(SLOTS);
  localparam int NB_W  = $clog2(NUM_BINS + 1);
  localparam int QW    = $clog2(NUM_BINS);
  localparam int SW    = $clog2(QW + 1);
  localparam int NUM_W = phh_pkg::DIFF_W + NB_W;

  localparam logic signed [phh_pkg::PROD_W-1:0] LOW_C  = phh_pkg::PROD_W'(HIST_LOW_MV);
  localparam logic signed [phh_pkg::PROD_W-1:0] HIGH_C = phh_pkg::PROD_W'(HIST_HIGH_MV);
  localparam logic [NUM_W-1:0] NB_C  = NUM_W'(NUM_BINS);
  localparam logic [BIN_W-1:0] OVF_C = BIN_W'(SLOTS - 1);

  phh_pkg::bin_state_t state_r, state_nxt;
  logic                done_r, done_nxt;
  logic [BIN_W-1:0]    bin_r, bin_nxt;

  logic signed [phh_pkg::SAMPLE_W-1:0] ext_r, ext_nxt;
  logic signed [phh_pkg::PROD_W-1:0]   p_r, p_nxt, lo_r, lo_nxt, hi_r, hi_nxt;
  logic [phh_pkg::DIFF_W-1:0]          diff_r, diff_nxt, span_r, span_nxt;
  logic [NUM_W-1:0]                    rem_r, rem_nxt, den_r, den_nxt;
  logic [QW-1:0]                       q_r, q_nxt;
  logic [SW-1:0]                       step_r, step_nxt;

  logic [phh_pkg::FSC_W-1:0]      f_eff;
  logic [phh_pkg::RANGE_MV_W-1:0] rng;
  logic                           ge;

  assign f_eff = (full_scale_count == '0) ? phh_pkg::FSC_W'(1) : full_scale_count;
  assign rng   = phh_pkg::range_mv(range_index);
  assign ge    = (rem_r >= den_r);

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    bin_nxt   = bin_r;
    ext_nxt   = ext_r;
    p_nxt     = p_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    diff_nxt  = diff_r;
    span_nxt  = span_r;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    q_nxt     = q_r;
    step_nxt  = step_r;
    case (state_r)
      phh_pkg::BS_IDLE: begin
        if (start) begin
          ext_nxt   = extreme;
          state_nxt = phh_pkg::BS_MUL;
        end
      end
      phh_pkg::BS_MUL: begin
        p_nxt     = ext_r * $signed({1'b0, rng});
        lo_nxt    = LOW_C * $signed({1'b0, f_eff});
        hi_nxt    = HIGH_C * $signed({1'b0, f_eff});
        state_nxt = phh_pkg::BS_CMP;
      end
      phh_pkg::BS_CMP: begin
        if (p_r < lo_r) begin
          bin_nxt   = '0;
          done_nxt  = 1'b1;
          state_nxt = phh_pkg::BS_IDLE;
        end else if (p_r >= hi_r) begin
          bin_nxt   = OVF_C;
          done_nxt  = 1'b1;
          state_nxt = phh_pkg::BS_IDLE;
        end else begin
          diff_nxt  = phh_pkg::DIFF_W'(p_r - lo_r);
          span_nxt  = phh_pkg::DIFF_W'(hi_r - lo_r);
          state_nxt = phh_pkg::BS_SCALE;
        end
      end
      phh_pkg::BS_SCALE: begin
        rem_nxt   = NUM_W'(diff_r) * NB_C;
        den_nxt   = NUM_W'(span_r) << (QW - 1);
        q_nxt     = '0;
        step_nxt  = SW'(QW - 1);
        state_nxt = phh_pkg::BS_DIV;
      end
      phh_pkg::BS_DIV: begin
        // one quotient bit a cycle, divisor walks down from the top bit
        rem_nxt  = ge ? rem_r - den_r : rem_r;
        den_nxt  = den_r >> 1;
        q_nxt    = QW'({q_r, ge});
        step_nxt = step_r - SW'(1);
        if (step_r == '0) begin
          bin_nxt   = BIN_W'(q_nxt) + BIN_W'(1);
          done_nxt  = 1'b1;
          state_nxt = phh_pkg::BS_IDLE;
        end
      end
      default: state_nxt = phh_pkg::BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= phh_pkg::BS_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    bin_r  <= bin_nxt;
    ext_r  <= ext_nxt;
    p_r    <= p_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    diff_r <= diff_nxt;
    span_r <= span_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    q_r    <= q_nxt;
    step_r <= step_nxt;
  end

  assign done = done_r;
  assign bin  = bin_r;

  a_bin_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (bin_r <= OVF_C))
    else $error("bin beyond overflow slot");

  a_span_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == phh_pkg::BS_SCALE) |-> (span_r != '0) && (diff_r < span_r))
    else $error("division entered with value outside the histogram span");

endmodule

### hdl/pulse_height_histogram_unit.sv
// Pulse-height histogram unit: tracks per-event extreme, bins it into a
// histogram RAM (phh_ram) via phh_binner. Uses phh_pkg.
//
// Samples that do not close an event are taken one per cycle while idle.
// A sample marked tlast starts the binning: product, edge compare,
// scaling, then a bit-serial divider giving one bit of the bin index per
// cycle, followed by a read-modify-write of the count RAM; the next beat
// is taken once that write is done; scaling and the divider are skipped
// when the value lands in the underflow or overflow bin. A readout beat
// goes through the registered RAM read (states RD, RDW, EMIT). After reset
// the RAM is cleared one bin a cycle, all NUM_BINS+2 bins, during which no
// beat is taken; the config port is live throughout. A finished result
// sits in an output register, so the next beat is taken while it waits.
module pulse_height_histogram_unit #(
  parameter int NUM_BINS     = 200,
  parameter int HIST_LOW_MV  = -100,
  parameter int HIST_HIGH_MV = 0,
  parameter int COUNT_BITS   = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,

  input  logic                               cfg_we,
  input  logic [phh_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [phh_pkg::CFG_DATA_W-1:0]     cfg_wdata,

  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [phh_pkg::IN_TDATA_W-1:0]     in_tdata,   // sample[15:0], read_bin[23:16]
  input  logic                               in_tlast,   // last_sample
  input  logic                               in_tuser,   // mode

  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [phh_pkg::OUT_TDATA_W-1:0]    out_tdata,  // event_extreme[15:0],
                                                         // bin_number[23:16], bin_count[55:24]
  output logic                               out_tuser   // result_kind
);

  localparam int SLOTS = NUM_BINS + 2;
  localparam int BIN_W = $clog2(SLOTS);
  localparam logic [BIN_W-1:0] LAST_SLOT = BIN_W'(SLOTS - 1);

  // config
  logic                          pol_r;
  logic [phh_pkg::RANGE_W-1:0]   range_r;
  logic [phh_pkg::FSC_W-1:0]     fsc_r;

  // control
  phh_pkg::top_state_t state_r, state_nxt;
  logic [BIN_W-1:0]    clr_r, clr_nxt;
  logic                out_valid_r, out_valid_nxt;

  // payload
  logic signed [phh_pkg::SAMPLE_W-1:0] run_r, run_nxt, ext_r, ext_nxt;
  logic [BIN_W-1:0]                    bin_r, bin_nxt;
  logic [phh_pkg::RB_W-1:0]            rb_r, rb_nxt;
  logic                                rb_ok_r, rb_ok_nxt;
  logic                                kind_r, kind_nxt;
  logic [COUNT_BITS-1:0]               count_r, count_nxt;
  logic                                out_kind_r, out_kind_nxt;
  logic signed [phh_pkg::SAMPLE_W-1:0] out_ext_r, out_ext_nxt;
  logic [phh_pkg::RB_W-1:0]            out_bin_r, out_bin_nxt;
  logic [phh_pkg::CNT_FIELD_W-1:0]     out_cnt_r, out_cnt_nxt;

  logic signed [phh_pkg::SAMPLE_W-1:0] in_sample, ext_upd;
  logic [phh_pkg::RB_W-1:0]            in_rb;
  logic                                in_acc, out_free, start;
  logic                                binner_done;
  logic [BIN_W-1:0]                    binner_bin;
  logic [15:0]                         bin_wide;
  logic [63:0]                         cnt_wide;

  logic                   ram_we;
  logic [BIN_W-1:0]       ram_waddr;
  logic [COUNT_BITS-1:0]  ram_wdata, ram_rdata;

  assign in_sample = $signed(in_tdata[15:0]);
  assign in_rb     = in_tdata[23:16];
  assign in_tready = (state_r == phh_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign start     = in_acc && (in_tuser == phh_pkg::MODE_SAMPLE) && in_tlast;
  assign bin_wide  = 16'(bin_r);
  assign cnt_wide  = 64'(count_r);

  // running extreme including the current sample
  always_comb begin
    ext_upd = run_r;
    if (pol_r) begin
      if (in_sample < run_r) ext_upd = in_sample;
    end else begin
      if (in_sample > run_r) ext_upd = in_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pol_r   <= phh_pkg::POL_RST;
      range_r <= phh_pkg::RANGE_RST;
      fsc_r   <= phh_pkg::FSC_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        phh_pkg::CFG_POLARITY: pol_r   <= cfg_wdata[0];
        phh_pkg::CFG_RANGE:    range_r <= cfg_wdata[phh_pkg::RANGE_W-1:0];
        phh_pkg::CFG_FSC:      fsc_r   <= cfg_wdata[phh_pkg::FSC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r;
    run_nxt       = run_r;
    ext_nxt       = ext_r;
    bin_nxt       = bin_r;
    rb_nxt        = rb_r;
    rb_ok_nxt     = rb_ok_r;
    kind_nxt      = kind_r;
    count_nxt     = count_r;
    out_kind_nxt  = out_kind_r;
    out_ext_nxt   = out_ext_r;
    out_bin_nxt   = out_bin_r;
    out_cnt_nxt   = out_cnt_r;
    ram_we        = 1'b0;
    ram_waddr     = bin_r;
    ram_wdata     = count_r;

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (state_r)
      phh_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + BIN_W'(1);
        if (clr_r == LAST_SLOT) state_nxt = phh_pkg::ST_IDLE;
      end
      phh_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == phh_pkg::MODE_READ) begin
            kind_nxt  = phh_pkg::KIND_READ;
            rb_nxt    = in_rb;
            rb_ok_nxt = (32'(in_rb) < 32'(SLOTS));
            bin_nxt   = BIN_W'(in_rb);
            state_nxt = phh_pkg::ST_RD;
          end else if (in_tlast) begin
            kind_nxt  = phh_pkg::KIND_EVENT;
            ext_nxt   = ext_upd;
            run_nxt   = '0;
            state_nxt = phh_pkg::ST_BIN;
          end else begin
            run_nxt = ext_upd;
          end
        end
      end
      phh_pkg::ST_BIN: begin
        if (binner_done) begin
          bin_nxt   = binner_bin;
          state_nxt = phh_pkg::ST_RD;
        end
      end
      phh_pkg::ST_RD: begin
        // read address is bin_r; data lands next cycle
        state_nxt = phh_pkg::ST_RDW;
      end
      phh_pkg::ST_RDW: begin
        if (kind_r == phh_pkg::KIND_READ) begin
          count_nxt = rb_ok_r ? ram_rdata : '0;
        end else begin
          count_nxt = (ram_rdata == '1) ? ram_rdata : ram_rdata + COUNT_BITS'(1);
        end
        state_nxt = phh_pkg::ST_EMIT;
      end
      phh_pkg::ST_EMIT: begin
        if (out_free) begin
          ram_we        = (kind_r == phh_pkg::KIND_EVENT);
          out_valid_nxt = 1'b1;
          out_kind_nxt  = kind_r;
          out_cnt_nxt   = cnt_wide[31:0];
          if (kind_r == phh_pkg::KIND_READ) begin
            out_ext_nxt = '0;
            out_bin_nxt = rb_r;
          end else begin
            out_ext_nxt = ext_r;
            out_bin_nxt = bin_wide[7:0];
          end
          state_nxt = phh_pkg::ST_IDLE;
        end
      end
      default: state_nxt = phh_pkg::ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= phh_pkg::ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      run_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      run_r       <= run_nxt;
    end
    ext_r      <= ext_nxt;
    bin_r      <= bin_nxt;
    rb_r       <= rb_nxt;
    rb_ok_r    <= rb_ok_nxt;
    kind_r     <= kind_nxt;
    count_r    <= count_nxt;
    out_kind_r <= out_kind_nxt;
    out_ext_r  <= out_ext_nxt;
    out_bin_r  <= out_bin_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  phh_binner #(
    .NUM_BINS     (NUM_BINS),
    .HIST_LOW_MV  (HIST_LOW_MV),
    .HIST_HIGH_MV (HIST_HIGH_MV)
  ) u_binner (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .extreme          (ext_upd),
    .range_index      (range_r),
    .full_scale_count (fsc_r),
    .done             (binner_done),
    .bin              (binner_bin)
  );

  phh_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (SLOTS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (bin_r),
    .rdata (ram_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {out_cnt_r, out_bin_r, out_ext_r};

  a_done_only_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    binner_done |-> (state_r == phh_pkg::ST_BIN))
    else $error("binner finished while sequencer not waiting");

  a_ram_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == phh_pkg::ST_CLEAR) ||
               ((state_r == phh_pkg::ST_EMIT) && (kind_r == phh_pkg::KIND_EVENT)))
    else $error("histogram write outside clear pass or event update");

  a_event_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (COUNT_BITS <= 32) && (state_r == phh_pkg::ST_EMIT) && out_free &&
    (kind_r == phh_pkg::KIND_EVENT) |=> out_valid_r && (out_cnt_r != '0))
    else $error("event result carries a zero count");

  a_no_result_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == phh_pkg::ST_CLEAR) |-> !out_valid_r && !in_tready)
    else $error("traffic during histogram clear pass");

endmodule

### test/tb_pulse_height_histogram_unit.sv
// Self-checking testbench for pulse_height_histogram_unit: a spectrum predictor with
// a queue of expected results, plus stream drivers with random idling and back-pressure.
// Depends on hdl/phh_pkg.sv and hdl/pulse_height_histogram_unit.sv.
`timescale 1ns / 100ps

module tb_pulse_height_histogram_unit;

  localparam int HIST_BINS    = 200;
  localparam int LOW_EDGE_MV  = -100;
  localparam int HIGH_EDGE_MV = 0;
  localparam int SETTLE_CYCLES = 30;    // margin for a binning still in flight
  localparam int STALL_LIMIT   = 2000;  // covers the clearing pass and the long hold-off
  localparam int PHASE_BEATS   = 200;
  localparam int HOLD_CYCLES   = 300;

  // {negative_polarity, range_index, full_scale_count} for each random phase
  localparam bit [19:0] PHASE_SETTINGS [9] = '{
    {1'b1, 4'd0,  15'd32512},
    {1'b1, 4'd8,  15'd32512},
    {1'b0, 4'd11, 15'd32767},
    {1'b1, 4'd4,  15'd1000},
    {1'b0, 4'd15, 15'd1},
    {1'b1, 4'd6,  15'd16384},
    {1'b1, 4'd11, 15'd1},
    {1'b0, 4'd2,  15'd300},
    {1'b1, 4'd9,  15'd32767}
  };

  typedef struct packed {
    logic        kind;
    logic [15:0] extreme;
    logic [7:0]  bin;
    logic [31:0] count;
  } spectrum_result_t;

  class phh_scoreboard;
    bit                 neg_pol;
    bit [3:0]           range_sel;
    bit [14:0]          full_scale;
    logic signed [15:0] peak;
    bit [31:0]          hist [HIST_BINS+2];
    longint             mv_table [12];
    spectrum_result_t   expected_q [$];
    int                 errors;
    int                 events;
    int                 readouts;

    function new();
      mv_table = '{10, 20, 50, 100, 200, 500, 1000, 2000, 5000, 10000, 20000, 50000};
      neg_pol    = phh_pkg::POL_RST;
      range_sel  = phh_pkg::RANGE_RST;
      full_scale = phh_pkg::FSC_RST;
      peak       = '0;
      foreach (hist[i]) hist[i] = '0;
      errors   = 0;
      events   = 0;
      readouts = 0;
    endfunction

    function void write_reg(logic [phh_pkg::CFG_ADDR_W-1:0] idx,
                            logic [phh_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        phh_pkg::CFG_POLARITY: neg_pol    = val[0];
        phh_pkg::CFG_RANGE:    range_sel  = val[phh_pkg::RANGE_W-1:0];
        phh_pkg::CFG_FSC:      full_scale = val[phh_pkg::FSC_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // exact integer binning: compare extreme*range against the edges scaled by full scale
    function int unsigned locate_bin(logic signed [15:0] ext);
      longint f, p, lo, hi;
      int unsigned ri;
      ri = (range_sel > 11) ? 11 : range_sel;
      f  = (full_scale == 0) ? 1 : full_scale;
      p  = longint'(ext) * mv_table[ri];
      lo = longint'(LOW_EDGE_MV) * f;
      hi = longint'(HIGH_EDGE_MV) * f;
      if (p < lo) return 0;
      if (p >= hi) return HIST_BINS + 1;
      return 1 + int'(((p - lo) * HIST_BINS) / (hi - lo));
    endfunction

    function void note_input(logic mode, logic [phh_pkg::IN_TDATA_W-1:0] data, logic last);
      logic signed [15:0] smp;
      logic [7:0]         rb;
      int unsigned        b;
      spectrum_result_t   r;
      smp = data[15:0];
      rb  = data[23:16];
      if (mode == phh_pkg::MODE_READ) begin
        r.kind    = phh_pkg::KIND_READ;
        r.extreme = '0;
        r.bin     = rb;
        r.count   = (rb < HIST_BINS + 2) ? hist[rb] : '0;
        expected_q = {expected_q, r};
        readouts++;
        return;
      end
      if (neg_pol) begin
        if (smp < peak) peak = smp;
      end else if (smp > peak) begin
        peak = smp;
      end
      if (!last) return;
      b = locate_bin(peak);
      if (hist[b] != 32'hFFFF_FFFF) hist[b]++;
      r.kind    = phh_pkg::KIND_EVENT;
      r.extreme = peak;
      r.bin     = b[7:0];
      r.count   = hist[b];
      expected_q = {expected_q, r};
      peak = '0;
      events++;
    endfunction

    function void compare_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(logic kind, logic [phh_pkg::OUT_TDATA_W-1:0] data);
      spectrum_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, actual kind %0d data %0h",
                 $time, kind, data);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      compare_field("result_kind", e.kind, kind);
      compare_field("event_extreme", $signed(e.extreme), $signed(data[15:0]));
      compare_field("bin_number", e.bin, data[23:16]);
      compare_field("bin_count", e.count, data[55:24]);
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [phh_pkg::CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [phh_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [phh_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                            in_tlast = 1'b0;
  logic                            in_tuser = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [phh_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tuser;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold = 0;
  int stall_cycles = 0;
  int beats_sent = 0;
  phh_scoreboard sb;

  pulse_height_histogram_unit #(
    .NUM_BINS     (HIST_BINS),
    .HIST_LOW_MV  (LOW_EDGE_MV),
    .HIST_HIGH_MV (HIGH_EDGE_MV),
    .COUNT_BITS   (32)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver: random back-pressure, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold != 0) begin
        out_tready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end
      out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // beats are sampled at the edge, before anything driven there takes effect
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
      if (in_tvalid && in_tready) sb.note_input(in_tuser, in_tdata, in_tlast);
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready) || cfg_we) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
          $display("tb_pulse_height_histogram_unit: errors");
          $finish;
        end
      end
    end
  end

  task automatic send_beat(input logic mode, input logic [15:0] smp, input logic last,
                           input logic [7:0] rb);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tlast  <= last;
    in_tdata  <= {rb, smp};
    do @(posedge clk); while (!in_tready);
    beats_sent++;
  endtask

  // stop offering, let every expected result arrive, then allow for a binning in flight
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input logic pol, input logic [3:0] rng, input logic [14:0] fs);
    settle();
    cfg_we    <= 1'b1;
    cfg_addr  <= phh_pkg::CFG_POLARITY;
    cfg_wdata <= phh_pkg::CFG_DATA_W'(pol);
    @(posedge clk);
    cfg_addr  <= phh_pkg::CFG_RANGE;
    cfg_wdata <= phh_pkg::CFG_DATA_W'(rng);
    @(posedge clk);
    cfg_addr  <= phh_pkg::CFG_FSC;
    cfg_wdata <= fs;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.write_reg(phh_pkg::CFG_POLARITY, phh_pkg::CFG_DATA_W'(pol));
    sb.write_reg(phh_pkg::CFG_RANGE, phh_pkg::CFG_DATA_W'(rng));
    sb.write_reg(phh_pkg::CFG_FSC, fs);
  endtask

  initial begin
    logic signed [15:0] smp;
    logic [19:0]        cur;
    logic [7:0]         rb;
    int                 pick, len, phase_start;

    sb = new();
    tx_idle_pct = 38;
    rx_idle_pct = 51;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: minimum tracking, 10 mV range
    send_beat(phh_pkg::MODE_SAMPLE, 16'h8000, 1'b1, 8'h00);
    send_beat(phh_pkg::MODE_SAMPLE, 16'h7fff, 1'b1, 8'hff);  // never below zero: overflow bin
    send_beat(phh_pkg::MODE_SAMPLE, -16'sd5, 1'b0, 8'h00);
    // readout inside an event leaves it alone
    send_beat(phh_pkg::MODE_READ, 16'h8000, 1'b1, 8'd0);
    send_beat(phh_pkg::MODE_SAMPLE, -16'sd300, 1'b0, 8'h55);
    send_beat(phh_pkg::MODE_SAMPLE, -16'sd20, 1'b1, 8'haa);
    send_beat(phh_pkg::MODE_READ, 16'hffff, 1'b0, 8'(HIST_BINS + 1));
    send_beat(phh_pkg::MODE_READ, 16'h0000, 1'b0, 8'(HIST_BINS + 2));
    send_beat(phh_pkg::MODE_READ, 16'h1234, 1'b1, 8'hff);

    // unit full scale: exactly on the low edge, just below it, inside
    apply_settings(1'b1, 4'd0, 15'd1);
    send_beat(phh_pkg::MODE_SAMPLE, -16'sd10, 1'b1, 8'h00);
    send_beat(phh_pkg::MODE_SAMPLE, -16'sd11, 1'b1, 8'h00);
    send_beat(phh_pkg::MODE_SAMPLE, -16'sd1, 1'b1, 8'h00);

    // max tracking, range index past the table, zero full scale
    apply_settings(1'b0, 4'd15, 15'd0);
    send_beat(phh_pkg::MODE_SAMPLE, 16'h7fff, 1'b1, 8'h00);
    send_beat(phh_pkg::MODE_SAMPLE, -16'sd1, 1'b1, 8'h00);

    // polarity flipped part way through an event
    apply_settings(1'b1, 4'd11, 15'd32767);
    send_beat(phh_pkg::MODE_SAMPLE, -16'sd40, 1'b0, 8'h00);
    apply_settings(1'b0, 4'd11, 15'd32767);
    send_beat(phh_pkg::MODE_SAMPLE, -16'sd60, 1'b0, 8'h00);
    send_beat(phh_pkg::MODE_SAMPLE, -16'sd45, 1'b1, 8'h00);

    apply_settings(1'b1, 4'd11, 15'd32767);
    send_beat(phh_pkg::MODE_SAMPLE, 16'h8000, 1'b1, 8'h00);
    send_beat(phh_pkg::MODE_SAMPLE, -16'sd65, 1'b1, 8'h00);
    send_beat(phh_pkg::MODE_READ, 16'h0000, 1'b0, 8'd0);

    for (int ph = 0; ph < 9; ph++) begin
      cur = PHASE_SETTINGS[ph];
      apply_settings(cur[19], cur[18:15], cur[14:0]);
      if (ph < 3) begin
        tx_idle_pct = 38;
        rx_idle_pct = 51;
      end else if (ph < 6) begin
        tx_idle_pct = 51;
        rx_idle_pct = 38;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      // receiver stalls while the sender keeps pushing, so the input backs up
      if (ph == 6) rx_hold = HOLD_CYCLES;
      phase_start = beats_sent;
      while (beats_sent - phase_start < PHASE_BEATS) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          rb = (pick < 12) ? 8'($urandom_range(0, HIST_BINS + 1)) : 8'($urandom_range(0, 255));
          send_beat(phh_pkg::MODE_READ, 16'($urandom), 1'($urandom), rb);
        end else begin
          len = $urandom_range(1, 6);
          for (int k = 0; k < len; k++) begin
            // spread magnitudes over the whole code range
            smp = 16'($urandom);
            smp = smp >>> $urandom_range(0, 15);
            send_beat(phh_pkg::MODE_SAMPLE, smp, k == len - 1, 8'($urandom));
          end
        end
      end
    end

    settle();
    $display("run covered %0d input beats: %0d events binned, %0d bins read back,",
             beats_sent, sb.events, sb.readouts);
    $display("over %0d register settings with and without idling on both sides", 14);
    if (sb.errors == 0) begin
      $display("tb_pulse_height_histogram_unit: clean");
    end else begin
      $display("tb_pulse_height_histogram_unit: errors");
    end
    $finish;
  end

endmodule
